// ----- rtl/core/edus_pkg.sv -----
`default_nettype none

package edus_pkg;

  localparam int unsigned PriceWidth = 40;
  localparam int unsigned TimeWidth  = 48;

  typedef logic [PriceWidth-1:0] price_t;
  typedef logic [TimeWidth-1:0]  stamp_t;

  // request opcodes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_FLUSH  = 1'b1;

  typedef struct packed {
    logic   op;
    price_t price;
    stamp_t timestamp;
  } sample_t;

  typedef struct packed {
    price_t start_price;
    stamp_t start_time;
    price_t end_price;
    stamp_t end_time;
    logic   is_final;
  } seg_t;

endpackage

`default_nettype wire

// ----- rtl/core/edus_if.sv -----
`default_nettype none

interface edus_in_if import edus_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   op;
  price_t price;
  stamp_t timestamp;

  modport source (output valid, output op, output price, output timestamp, input ready);
  modport sink   (input valid, input op, input price, input timestamp, output ready);
endinterface

interface edus_out_if import edus_pkg::*; ();
  logic   valid;
  logic   ready;
  price_t start_price;
  stamp_t start_time;
  price_t end_price;
  stamp_t end_time;
  logic   is_final;

  modport source (output valid, output start_price, output start_time, output end_price,
                  output end_time, output is_final, input ready);
  modport sink   (input valid, input start_price, input start_time, input end_price,
                  input end_time, input is_final, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/edus_in_reg.sv -----
`default_nettype none

module edus_in_reg import edus_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire sample_t in_data,
  input  wire logic    advance,
  output logic         valid,
  output sample_t      data
);

  logic accept;

  assign in_ready = !valid || advance;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (accept) begin
      valid <= 1'b1;
    end else if (advance) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      data <= in_data;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/edus_core.sv -----
`default_nettype none

module edus_core import edus_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire price_t  epsilon,
  input  wire logic    fire,
  input  wire sample_t item,
  output logic         emit,
  output seg_t         seg
);

  logic   have_start;
  price_t seg_start_price;
  stamp_t seg_start_time;
  price_t turn_price;
  stamp_t turn_time;
  price_t last_price;
  stamp_t last_time;

  logic   have_start_next;
  price_t seg_start_price_next;
  stamp_t seg_start_time_next;
  price_t turn_price_next;
  stamp_t turn_time_next;
  price_t last_price_next;
  stamp_t last_time_next;

  logic   extend;
  price_t delta;

  assign extend = ((turn_price >= seg_start_price) && (item.price > turn_price)) ||
                  ((turn_price <= seg_start_price) && (item.price < turn_price));
  assign delta  = (item.price > turn_price) ? item.price - turn_price
                                            : turn_price - item.price;

  always_comb begin
    have_start_next      = have_start;
    seg_start_price_next = seg_start_price;
    seg_start_time_next  = seg_start_time;
    turn_price_next      = turn_price;
    turn_time_next       = turn_time;
    last_price_next      = last_price;
    last_time_next       = last_time;
    emit                 = 1'b0;
    seg.start_price      = seg_start_price;
    seg.start_time       = seg_start_time;
    seg.end_price        = turn_price;
    seg.end_time         = turn_time;
    seg.is_final         = 1'b0;

    case (item.op)
      OP_FLUSH: begin
        emit                 = have_start && (last_time > seg_start_time);
        seg.end_price        = last_price;
        seg.end_time         = last_time;
        seg.is_final         = 1'b1;
        have_start_next      = 1'b0;
        seg_start_price_next = '0;
        seg_start_time_next  = '0;
        turn_price_next      = '0;
        turn_time_next       = '0;
        last_price_next      = '0;
        last_time_next       = '0;
      end
      OP_SAMPLE: begin
        last_price_next = item.price;
        last_time_next  = item.timestamp;
        if (!have_start) begin
          have_start_next      = 1'b1;
          seg_start_price_next = item.price;
          seg_start_time_next  = item.timestamp;
          turn_price_next      = item.price;
          turn_time_next       = item.timestamp;
        end else if (item.price == turn_price) begin
          // flat against the turning point
        end else if (extend) begin
          turn_price_next = item.price;
          turn_time_next  = item.timestamp;
        end else if (delta > epsilon) begin
          // reversal closes the segment, turning point becomes new start
          emit                 = 1'b1;
          seg_start_price_next = turn_price;
          seg_start_time_next  = turn_time;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_start      <= 1'b0;
      seg_start_price <= '0;
      seg_start_time  <= '0;
      turn_price      <= '0;
      turn_time       <= '0;
      last_price      <= '0;
      last_time       <= '0;
    end else if (fire) begin
      have_start      <= have_start_next;
      seg_start_price <= seg_start_price_next;
      seg_start_time  <= seg_start_time_next;
      turn_price      <= turn_price_next;
      turn_time       <= turn_time_next;
      last_price      <= last_price_next;
      last_time       <= last_time_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/edus_out_reg.sv -----
`default_nettype none

module edus_out_reg import edus_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic fire,
  input  wire logic emit,
  input  wire seg_t seg_in,
  output logic      free,
  output logic      valid,
  input  wire logic ready,
  output seg_t      data
);

  assign free = !valid || ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (free) begin
      valid <= fire && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (free && fire && emit) begin
      data <= seg_in;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/epsilon_drawupdown_segmenter.sv -----
// epsilon draw-up / draw-down segmenter
//
// samples: request channel of price ticks (op = sample) and end-of-stream
//   flush markers (op = flush); price and timestamp are ignored on a flush
// segments: one request per closed segment, start point to turning point,
//   or start point to last sample on a flush (is_final set)
// cfg_we / cfg_wdata: writes the 40-bit reversal threshold epsilon
//
// pipeline: a request is registered at the input register and decided
//   against the segment state once the result register can take it; a
//   segment it closes is loaded into the result register and shows up on
//   the segment channel from there
// throughput: one request per cycle while the result register is free; the
//   state update is one compare/subtract path from input to result register
// stall: the result register holds while segments.ready is low; samples
//   keep flowing only while the result register is empty or being taken
// reset (rst, synchronous): clears the segment state, both pipeline valids
//   and epsilon
`default_nettype none

module epsilon_drawupdown_segmenter import edus_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  edus_in_if.sink     samples,
  edus_out_if.source  segments,
  input  wire logic   cfg_we,
  input  wire price_t cfg_wdata
);

  price_t  epsilon;
  sample_t in_data;
  sample_t item;
  logic    item_valid;
  logic    free;
  logic    fire;
  logic    emit;
  seg_t    seg;
  seg_t    seg_q;

  // threshold register, written by the user only while the block is idle; not enforced
  always_ff @(posedge clk) begin
    if (rst) begin
      epsilon <= '0;
    end else if (cfg_we) begin
      epsilon <= cfg_wdata;
    end
  end

  assign in_data.op        = samples.op;
  assign in_data.price     = samples.price;
  assign in_data.timestamp = samples.timestamp;

  // the registered request is processed once the result slot can take it
  assign fire = item_valid && free;

  edus_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_ready (samples.ready),
    .in_data  (in_data),
    .advance  (free),
    .valid    (item_valid),
    .data     (item)
  );

  edus_core u_core (
    .clk     (clk),
    .rst     (rst),
    .epsilon (epsilon),
    .fire    (fire),
    .item    (item),
    .emit    (emit),
    .seg     (seg)
  );

  edus_out_reg u_out_reg (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .emit   (emit),
    .seg_in (seg),
    .free   (free),
    .valid  (segments.valid),
    .ready  (segments.ready),
    .data   (seg_q)
  );

  assign segments.start_price = seg_q.start_price;
  assign segments.start_time  = seg_q.start_time;
  assign segments.end_price   = seg_q.end_price;
  assign segments.end_time    = seg_q.end_time;
  assign segments.is_final    = seg_q.is_final;

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
module tb;
  import edus_pkg::*;

  // run limits
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 6;    // two-stage pipeline plus margin
  localparam int unsigned PhaseItems  = 345;
  localparam int unsigned HoldCycles  = 300;

  localparam price_t PMax = '1;
  localparam stamp_t TMax = '1;

  // how a directed row is checked
  typedef enum logic [1:0] {
    CHK_MODEL,  // expectation from the local predictor
    CHK_NONE,   // no segment may come out
    CHK_GIVEN   // segment typed into the table
  } chk_t;

  typedef struct {
    chk_t    how;
    sample_t req;
    seg_t    want;
  } dir_row_t;

  logic   clk;
  logic   rst;
  logic   cfg_we;
  price_t cfg_wdata;

  edus_in_if  samples ();
  edus_out_if segments ();

  epsilon_drawupdown_segmenter i_dut (
    .clk       (clk),
    .rst       (rst),
    .samples   (samples),
    .segments  (segments),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // segment tracker state, mirrors the block
  price_t eps_cfg;
  bit     held;
  price_t leg_p0;
  stamp_t leg_t0;
  price_t pivot_p;
  stamp_t pivot_t;
  price_t recent_p;
  stamp_t recent_t;

  seg_t        seg_expected[$];
  dir_row_t    dir_rows[$];
  int unsigned n_sent;
  int unsigned n_err;
  int unsigned cycles;
  int unsigned calm_left;

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // cycle counter and watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
  end

  initial begin
    wait (cycles >= CycleLimit);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic price_t rand_price();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[39:0];
  endfunction

  function automatic stamp_t rand_stamp();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[47:0];
  endfunction

  // next segment out of one request; also advances the tracker state
  function automatic bit predict_segment(input sample_t s, output seg_t r);
    price_t d;
    bit     hit;
    r = '0;
    if (s.op == OP_FLUSH) begin
      // final leg only when time moved on past the leg start
      hit = held && (recent_t > leg_t0);
      if (hit) begin
        r = seg_t'{leg_p0, leg_t0, recent_p, recent_t, 1'b1};
      end
      held     = 1'b0;
      leg_p0   = '0;
      leg_t0   = '0;
      pivot_p  = '0;
      pivot_t  = '0;
      recent_p = '0;
      recent_t = '0;
      return hit;
    end
    // first price of a period opens the leg and the pivot
    if (!held) begin
      held     = 1'b1;
      leg_p0   = s.price;
      leg_t0   = s.timestamp;
      pivot_p  = s.price;
      pivot_t  = s.timestamp;
      recent_p = s.price;
      recent_t = s.timestamp;
      return 1'b0;
    end
    recent_p = s.price;
    recent_t = s.timestamp;
    if (s.price == pivot_p) begin
      return 1'b0;
    end
    // move further in the draw direction (either way while start == pivot)
    if ((pivot_p >= leg_p0 && s.price > pivot_p) ||
        (pivot_p <= leg_p0 && s.price < pivot_p)) begin
      pivot_p = s.price;
      pivot_t = s.timestamp;
      return 1'b0;
    end
    // reversal: closes the leg only when strictly larger than epsilon
    d = (s.price > pivot_p) ? s.price - pivot_p : pivot_p - s.price;
    if (d > eps_cfg) begin
      r      = seg_t'{leg_p0, leg_t0, pivot_p, pivot_t, 1'b0};
      leg_p0 = pivot_p;
      leg_t0 = pivot_t;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // sender idle gaps: mostly none or short, a few long, some calm stretches
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm_left != 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void flag_error(input string msg);
    n_err++;
    if (n_err <= 10) $display("%s", msg);
  endfunction

  function automatic void add_row(input chk_t how, input logic op, input price_t p,
                                  input stamp_t ts, input seg_t want);
    dir_row_t row;
    row.how  = how;
    row.req  = sample_t'{op, p, ts};
    row.want = want;
    dir_rows.push_back(row);
  endfunction

  // offer one request, hold it until taken, then maybe idle
  task automatic push_sample(input sample_t s, input chk_t how, input seg_t want);
    seg_t        pred;
    int unsigned gap;
    samples.valid     <= 1'b1;
    samples.op        <= s.op;
    samples.price     <= s.price;
    samples.timestamp <= s.timestamp;
    do @(posedge clk); while (samples.ready !== 1'b1);
    n_sent++;
    if (predict_segment(s, pred) && how == CHK_MODEL) seg_expected.push_back(pred);
    if (how == CHK_GIVEN) seg_expected.push_back(want);
    @(negedge clk);
    gap = pick_gap();
    if (gap != 0) begin
      samples.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // quiet the input, let every segment drain, then write epsilon
  task automatic write_epsilon(input price_t v);
    samples.valid <= 1'b0;
    while (seg_expected.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    eps_cfg    = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // random walk of prices with occasional flushes and jumps
  task automatic run_phase(input int unsigned n);
    price_t      px;
    price_t      step;
    stamp_t      tx;
    sample_t     s;
    logic [63:0] w;
    int unsigned r;
    px = rand_price();
    tx = rand_stamp() >> $urandom_range(0, 8);
    repeat (n) begin
      r    = $urandom_range(0, 99);
      s.op = OP_SAMPLE;
      if (r < 3) begin
        // end marker with junk in the ignored fields
        s.op        = OP_FLUSH;
        s.price     = rand_price();
        s.timestamp = rand_stamp();
      end else if (r < 8) begin
        // jump anywhere, breaks the walk
        px          = rand_price();
        tx          = rand_stamp();
        s.price     = px;
        s.timestamp = tx;
      end else begin
        r = $urandom_range(0, 9);
        w = {$urandom, $urandom};
        if (r == 0) begin
          step = '0;
        end else if (r < 5) begin
          step = price_t'(w % ({24'd0, eps_cfg} + 64'd1));
        end else begin
          step = eps_cfg + price_t'($urandom_range(1, 256));
        end
        px = ($urandom_range(0, 1) != 0) ? px + step : px - step;
        r  = $urandom_range(0, 19);
        if (r == 0) begin
          tx = rand_stamp();
        end else if (r != 1) begin
          tx = tx + stamp_t'($urandom_range(1, 5000));
        end
        s.price     = px;
        s.timestamp = tx;
      end
      push_sample(s, CHK_MODEL, '0);
    end
  endtask

  // segment sink: random stalls, plus long hold-offs to back up the input
  initial begin
    int unsigned hold_mark;
    int unsigned len;
    int unsigned r;
    hold_mark      = 200;
    segments.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (n_sent >= hold_mark && hold_mark <= 1000) begin
        segments.ready <= 1'b0;
        hold_mark += 800;
        len = HoldCycles;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          segments.ready <= 1'b1;
          len = $urandom_range(1, 20);
        end else if (r < 90) begin
          segments.ready <= 1'b0;
          len = $urandom_range(1, 3);
        end else begin
          segments.ready <= 1'b0;
          len = $urandom_range(8, 30);
        end
      end
      repeat (len) @(negedge clk);
    end
  end

  // compare each taken segment with the oldest expectation
  always @(posedge clk) begin
    seg_t got;
    seg_t want;
    if (!rst && segments.valid === 1'b1 && segments.ready === 1'b1) begin
      got = seg_t'{segments.start_price, segments.start_time, segments.end_price,
                   segments.end_time, segments.is_final};
      if (seg_expected.size() == 0) begin
        flag_error($sformatf("unexpected segment %h/%h -> %h/%h final %b",
                             got.start_price, got.start_time, got.end_price,
                             got.end_time, got.is_final));
      end else begin
        want = seg_expected.pop_front();
        if (got.start_price !== want.start_price || got.start_time !== want.start_time ||
            got.end_price !== want.end_price || got.end_time !== want.end_time ||
            got.is_final !== want.is_final) begin
          flag_error($sformatf(
            "segment mismatch: exp %h/%h -> %h/%h final %b, got %h/%h -> %h/%h final %b",
            want.start_price, want.start_time, want.end_price, want.end_time,
            want.is_final, got.start_price, got.start_time, got.end_price,
            got.end_time, got.is_final));
        end
      end
    end
  end

  // stimulus
  initial begin
    price_t eps_list[5];
    seg_t   pred;
    cycles            = 0;
    n_sent            = 0;
    n_err             = 0;
    calm_left         = 0;
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    samples.valid     = 1'b0;
    samples.op        = OP_SAMPLE;
    samples.price     = '0;
    samples.timestamp = '0;
    eps_cfg           = '0;
    // flush request clears the tracker to its reset state
    void'(predict_segment(sample_t'{OP_FLUSH, '0, '0}, pred));

    // directed walk, epsilon 5: draw-up, small reversals, closing reversal,
    // price extremes, flush cases
    add_row(CHK_NONE,  OP_FLUSH,  PMax,     TMax,     '0);  // nothing held yet
    add_row(CHK_NONE,  OP_SAMPLE, 40'd100,  48'd10,   '0);  // first sample
    add_row(CHK_NONE,  OP_SAMPLE, 40'd100,  48'd11,   '0);  // equal to pivot
    add_row(CHK_MODEL, OP_SAMPLE, 40'd103,  48'd12,   '0);  // start == pivot, goes up
    add_row(CHK_MODEL, OP_SAMPLE, 40'd110,  48'd13,   '0);  // new high
    add_row(CHK_NONE,  OP_SAMPLE, 40'd106,  48'd14,   '0);  // reversal below epsilon
    add_row(CHK_NONE,  OP_SAMPLE, 40'd105,  48'd15,   '0);  // reversal equal to epsilon
    add_row(CHK_GIVEN, OP_SAMPLE, 40'd104,  48'd16,
            seg_t'{40'd100, 48'd10, 40'd110, 48'd13, 1'b0});
    add_row(CHK_MODEL, OP_SAMPLE, 40'd104,  48'd17,   '0);  // draw-down from new start
    add_row(CHK_MODEL, OP_SAMPLE, 40'd0,    48'd18,   '0);  // lowest price
    add_row(CHK_GIVEN, OP_SAMPLE, PMax,     48'd19,
            seg_t'{40'd110, 48'd13, 40'd0, 48'd18, 1'b0});
    add_row(CHK_MODEL, OP_SAMPLE, PMax,     48'd20,   '0);
    add_row(CHK_GIVEN, OP_SAMPLE, 40'd0,    48'd21,
            seg_t'{40'd0, 48'd18, PMax, 48'd20, 1'b0});
    add_row(CHK_GIVEN, OP_FLUSH,  40'd0,    48'd0,
            seg_t'{PMax, 48'd20, 40'd0, 48'd21, 1'b1});
    add_row(CHK_NONE,  OP_FLUSH,  40'd0,    48'd0,    '0);  // flush right after flush
    add_row(CHK_NONE,  OP_SAMPLE, 40'd50,   TMax,     '0);
    add_row(CHK_MODEL, OP_SAMPLE, 40'd60,   48'd0,    '0);  // time went backwards
    add_row(CHK_NONE,  OP_FLUSH,  PMax,     TMax,     '0);  // no time advance
    add_row(CHK_NONE,  OP_SAMPLE, PMax,     48'd0,    '0);
    add_row(CHK_NONE,  OP_FLUSH,  40'd0,    48'd0,    '0);  // single sample only
    add_row(CHK_NONE,  OP_SAMPLE, 40'd0,    48'd5,    '0);
    add_row(CHK_NONE,  OP_SAMPLE, 40'd0,    48'd6,    '0);
    add_row(CHK_GIVEN, OP_FLUSH,  PMax,     TMax,
            seg_t'{40'd0, 48'd5, 40'd0, 48'd6, 1'b1});

    // synchronous reset, released on a falling edge
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_epsilon(40'd5);
    foreach (dir_rows[i]) begin
      push_sample(dir_rows[i].req, dir_rows[i].how, dir_rows[i].want);
    end

    // random phases over several thresholds, extremes included
    eps_list[0] = '0;
    eps_list[1] = price_t'($urandom_range(1, 1000));
    eps_list[2] = 40'd1;
    eps_list[3] = PMax;
    eps_list[4] = rand_price() >> $urandom_range(0, 39);
    foreach (eps_list[k]) begin
      write_epsilon(eps_list[k]);
      run_phase(PhaseItems);
    end

    // wait for the last segments, then drain the pipeline for stragglers
    samples.valid <= 1'b0;
    while (seg_expected.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);

    if (n_err == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
